>>> rtl/gse_pkg.sv
// ---------------------------------------------------------------------------
// gse_pkg
// Shared types, constants and arithmetic helpers of the Gaussian elimination
// solver: request payloads, controller states, datapath commands and status.
// ---------------------------------------------------------------------------
`default_nettype none

package gse_pkg;

  // default dimension and field widths
  localparam int MAX_UNKNOWNS_DEF = 16;
  localparam int DATA_W           = 32;
  localparam int FRAC_W           = 16;
  localparam int IDX_W            = 4;
  localparam int SIZE_W           = 5;
  localparam int THR_W            = 31;
  localparam int CFG_IDX_W        = 1;
  localparam int SIZE_RESET       = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_IN_USE        = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SINGULAR_THRESHOLD = 1'b1;

  // request payloads
  typedef struct packed {
    logic signed [DATA_W-1:0] element_value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] solution_value;
    logic [IDX_W-1:0]         solution_index;
    logic                     singular_flag;
    logic                     last_result;
  } out_item_t;

  // controller states
  typedef enum logic [4:0] {
    S_LOAD, S_PV_RD, S_PV_CMP, S_PV_CHK,
    S_SW_RDA, S_SW_RDB, S_SW_WRA, S_SW_WRB,
    S_EL_RDP, S_EL_PIV, S_EL_RDJ, S_EL_DIV, S_EL_WAIT,
    S_UP_RDI, S_UP_MUL, S_UP_WR,
    S_BS_INIT, S_BS_RDA, S_BS_RDX, S_BS_MUL, S_BS_ACC,
    S_BS_RDB, S_BS_RDD, S_BS_DIV, S_BS_WAIT, S_BS_WR,
    S_OUT_RD, S_OUT_WR, S_SING
  } state_t;

  // datapath operations
  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_READ, OP_PV_CMP,
    OP_SW_RDB, OP_SW_WRA, OP_SW_WRB,
    OP_PIV, OP_LAM_DIV, OP_UP_MUL, OP_UP_WR,
    OP_ACC_CLR, OP_RD_TMP, OP_BS_MUL, OP_BS_ACC, OP_RD_NUM,
    OP_X_DIV, OP_X_WR, OP_OUT, OP_SING
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   last;
  } dp_cmd_t;

  typedef struct packed {
    logic singular;
    logic swap;
    logic div_done;
    logic out_free;
  } dp_status_t;

  // saturate a wide signed value to the data width
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (v > hi) begin
      sat32 = DATA_W'(hi);
    end else if (v < lo) begin
      sat32 = DATA_W'(lo);
    end else begin
      sat32 = DATA_W'(v);
    end
  endfunction

  // drop the fraction bits of a product, rounding toward zero
  function automatic logic signed [63:0] trunc_frac(input logic signed [63:0] p);
    logic signed [63:0] bias;
    bias = (64'sd1 <<< FRAC_W) - 64'sd1;
    if (p < 0) begin
      trunc_frac = (p + bias) >>> FRAC_W;
    end else begin
      trunc_frac = p >>> FRAC_W;
    end
  endfunction

endpackage

`default_nettype wire

>>> rtl/gse_stream_if.sv
// ---------------------------------------------------------------------------
// gse_stream_if
// Valid/ready channel carrying one payload item per request.
// ---------------------------------------------------------------------------
`default_nettype none

interface gse_stream_if #(parameter type item_t = logic) ();
  logic  valid;
  logic  ready;
  item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> rtl/gse_div.sv
// ---------------------------------------------------------------------------
// gse_div
// Radix-2 restoring divider: (dividend * 2^16) / divisor, truncated toward
// zero and saturated, one quotient bit a cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module gse_div import gse_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [DATA_W-1:0] dividend,
  input  logic signed [DATA_W-1:0] divisor,
  output logic                     busy,
  output logic                     done,
  output logic signed [DATA_W-1:0] quot
);

  localparam int NUM_W = DATA_W + FRAC_W;
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]  shreg;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] dvs;
  logic              neg;
  logic [CNT_W-1:0]  cnt;
  logic [DATA_W-1:0] dvd_mag;
  logic [DATA_W-1:0] dvs_mag;
  logic [DATA_W:0]   rem_sh;
  logic [DATA_W:0]   rem_sub;
  logic              ge;
  logic signed [NUM_W:0] q_signed;

  // operand magnitudes and one trial subtraction
  always_comb begin
    dvd_mag  = dividend[DATA_W-1] ? DATA_W'(-dividend) : DATA_W'(dividend);
    dvs_mag  = divisor[DATA_W-1] ? DATA_W'(-divisor) : DATA_W'(divisor);
    rem_sh   = {rem, shreg[NUM_W-1]};
    ge       = (rem_sh >= {1'b0, dvs});
    rem_sub  = rem_sh - {1'b0, dvs};
    q_signed = neg ? -$signed({1'b0, shreg}) : $signed({1'b0, shreg});
    quot     = sat32(64'(q_signed));
  end

  // iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // numerator shifts out while quotient bits shift in
  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= {dvd_mag, {FRAC_W{1'b0}}};
      rem   <= '0;
      dvs   <= dvs_mag;
      neg   <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
    end else if (busy) begin
      shreg <= {shreg[NUM_W-2:0], ge};
      rem   <= ge ? rem_sub[DATA_W-1:0] : rem_sh[DATA_W-1:0];
    end
  end

endmodule

`default_nettype wire

>>> rtl/gse_datapath.sv
// ---------------------------------------------------------------------------
// gse_datapath
// Matrix store, pivot search, shared multiplier, accumulator, divider and
// the result register, driven one command a cycle by the controller.
// ---------------------------------------------------------------------------
`default_nettype none

module gse_datapath import gse_pkg::*; #(
  parameter int MAX_UNKNOWNS = MAX_UNKNOWNS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  dp_cmd_t                               cmd,
  input  logic [$clog2(MAX_UNKNOWNS+1)-1:0]     row,
  input  logic [$clog2(MAX_UNKNOWNS+1)-1:0]     col,
  input  logic [$clog2(MAX_UNKNOWNS+1)-1:0]     n,
  input  logic [THR_W-1:0]                      thr,
  input  logic                                  in_fire,
  input  in_item_t                              in_item,
  input  logic                                  out_ready,
  output dp_status_t                            status,
  output logic                                  out_valid,
  output out_item_t                             out_item
);

  localparam int RCW   = $clog2(MAX_UNKNOWNS + 1);
  localparam int WW    = $clog2(MAX_UNKNOWNS + 2);
  localparam int DEPTH = MAX_UNKNOWNS * (MAX_UNKNOWNS + 1);
  localparam int AW    = $clog2(DEPTH);
  localparam int ACC_W = 2 * DATA_W - FRAC_W + $clog2(MAX_UNKNOWNS);

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] rdata;
  logic signed [DATA_W-1:0] tmp;
  logic signed [DATA_W-1:0] piv;
  logic [DATA_W:0]          best_mag;
  logic [RCW-1:0]           best_row;
  logic signed [63:0]       prod;
  logic signed [ACC_W-1:0]  acc;

  logic [RCW-1:0]           arow;
  logic [WW-1:0]            w;
  logic [AW-1:0]            addr;
  logic                     mem_we;
  logic                     mem_re;
  logic signed [DATA_W-1:0] wdata;
  logic [DATA_W:0]          cur_mag;
  logic                     div_start;
  logic                     div_busy;
  logic                     div_done;
  logic signed [DATA_W-1:0] div_a;
  logic signed [DATA_W-1:0] div_b;
  logic signed [DATA_W-1:0] quot;
  logic                     out_load;

  // address of element (row, col) in a row-major store of n+1 columns
  always_comb begin
    arow = (cmd.op == OP_SW_RDB || cmd.op == OP_SW_WRB) ? best_row : row;
    w    = WW'(n) + WW'(1);
    addr = AW'(AW'(arow) * AW'(w) + AW'(col));
  end

  // memory strobes and write data
  always_comb begin
    mem_re = cmd.op inside {OP_READ, OP_SW_RDB, OP_RD_TMP, OP_UP_MUL, OP_RD_NUM};
    mem_we = (cmd.op == OP_LOAD && in_fire) ||
             (cmd.op inside {OP_SW_WRA, OP_SW_WRB, OP_UP_WR, OP_X_WR});
    case (cmd.op)
      OP_LOAD:   wdata = in_item.element_value;
      OP_SW_WRA: wdata = rdata;
      OP_SW_WRB: wdata = tmp;
      OP_UP_WR:  wdata = sat32(64'(rdata) - trunc_frac(prod));
      OP_X_WR:   wdata = quot;
      default:   wdata = rdata;
    endcase
  end

  // matrix store, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr] <= wdata;
    end
    if (mem_re) begin
      rdata <= mem[addr];
    end
  end

  // magnitude of the candidate pivot
  always_comb begin
    cur_mag = rdata[DATA_W-1] ? ({1'b0, ~rdata} + (DATA_W+1)'(1)) : {1'b0, rdata};
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_PV_CMP: begin
        if (row == col || cur_mag > best_mag) begin
          best_mag <= cur_mag;
          best_row <= row;
        end
      end
      OP_SW_RDB: tmp <= rdata;
      OP_PIV:    piv <= rdata;
      OP_UP_MUL: prod <= rdata * quot;
      OP_ACC_CLR: acc <= '0;
      OP_RD_TMP: tmp <= rdata;
      OP_BS_MUL: prod <= tmp * rdata;
      OP_BS_ACC: acc <= acc + ACC_W'(trunc_frac(prod));
      OP_RD_NUM: tmp <= sat32(64'(rdata) - 64'(acc));
      default: begin
      end
    endcase
  end

  // shared divider: multiplier lambda and each solution element
  always_comb begin
    div_start = (cmd.op == OP_LAM_DIV) || (cmd.op == OP_X_DIV);
    div_a     = (cmd.op == OP_LAM_DIV) ? rdata : tmp;
    div_b     = (cmd.op == OP_LAM_DIV) ? piv : rdata;
  end

  gse_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (quot)
  );

  // result register
  assign out_load = (cmd.op == OP_OUT) || (cmd.op == OP_SING);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item.solution_value <= (cmd.op == OP_SING) ? '0 : rdata;
      out_item.solution_index <= IDX_W'(row);
      out_item.singular_flag  <= (cmd.op == OP_SING);
      out_item.last_result    <= (cmd.op == OP_SING) ? 1'b1 : cmd.last;
    end
  end

  // status back to the controller
  always_comb begin
    status.singular = (best_mag <= {2'b00, thr});
    status.swap     = (best_row != row);
    status.div_done = div_done;
    status.out_free = !out_valid || out_ready;
  end

  // checks
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_valid || out_ready))
    else $error("result register overwritten before it was taken");

  a_sing_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.singular_flag) |-> out_item.last_result)
    else $error("singular result not marked last");

endmodule

`default_nettype wire

>>> rtl/gse_ctrl.sv
// ---------------------------------------------------------------------------
// gse_ctrl
// Configuration registers, loop counters and the sequencing state machine
// for loading, pivoting, elimination, back substitution and result output.
// ---------------------------------------------------------------------------
`default_nettype none

module gse_ctrl import gse_pkg::*; #(
  parameter int MAX_UNKNOWNS = MAX_UNKNOWNS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [CFG_IDX_W-1:0]              cfg_index,
  input  logic [THR_W-1:0]                  cfg_data,
  input  logic                              in_fire,
  input  dp_status_t                        status,
  output logic                              in_ready,
  output dp_cmd_t                           cmd,
  output logic [$clog2(MAX_UNKNOWNS+1)-1:0] row,
  output logic [$clog2(MAX_UNKNOWNS+1)-1:0] col,
  output logic [$clog2(MAX_UNKNOWNS+1)-1:0] n,
  output logic [THR_W-1:0]                  thr
);

  localparam int RCW = $clog2(MAX_UNKNOWNS + 1);

  state_t          state;
  state_t          state_next;
  logic [SIZE_W-1:0] size_reg;
  logic [RCW-1:0]  i;
  logic [RCW-1:0]  j;
  logic [RCW-1:0]  k;
  logic [RCW-1:0]  n_m1;

  // active size, clamped to 1..MAX_UNKNOWNS
  always_comb begin
    if (size_reg == '0) begin
      n = RCW'(1);
    end else if (int'(size_reg) > MAX_UNKNOWNS) begin
      n = RCW'(MAX_UNKNOWNS);
    end else begin
      n = RCW'(size_reg);
    end
    n_m1 = n - RCW'(1);
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      size_reg <= SIZE_W'(SIZE_RESET);
      thr      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SIZE_IN_USE:        size_reg <= cfg_data[SIZE_W-1:0];
        REG_SINGULAR_THRESHOLD: thr      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_LOAD:    if (in_fire && k == n && i == n_m1) state_next = S_PV_RD;
      S_PV_RD:   state_next = S_PV_CMP;
      S_PV_CMP:  state_next = (j == n_m1) ? S_PV_CHK : S_PV_RD;
      S_PV_CHK: begin
        if (status.singular)  state_next = S_SING;
        else if (status.swap) state_next = S_SW_RDA;
        else                  state_next = S_EL_RDP;
      end
      S_SW_RDA:  state_next = S_SW_RDB;
      S_SW_RDB:  state_next = S_SW_WRA;
      S_SW_WRA:  state_next = S_SW_WRB;
      S_SW_WRB:  state_next = (k == n) ? S_EL_RDP : S_SW_RDA;
      S_EL_RDP:  state_next = (i == n_m1) ? S_BS_INIT : S_EL_PIV;
      S_EL_PIV:  state_next = S_EL_RDJ;
      S_EL_RDJ:  state_next = S_EL_DIV;
      S_EL_DIV:  state_next = S_EL_WAIT;
      S_EL_WAIT: if (status.div_done) state_next = S_UP_RDI;
      S_UP_RDI:  state_next = S_UP_MUL;
      S_UP_MUL:  state_next = S_UP_WR;
      S_UP_WR: begin
        if (k != n)          state_next = S_UP_RDI;
        else if (j != n_m1)  state_next = S_EL_RDJ;
        else                 state_next = S_PV_RD;
      end
      S_BS_INIT: state_next = (i == n_m1) ? S_BS_RDB : S_BS_RDA;
      S_BS_RDA:  state_next = S_BS_RDX;
      S_BS_RDX:  state_next = S_BS_MUL;
      S_BS_MUL:  state_next = S_BS_ACC;
      S_BS_ACC:  state_next = (j == n_m1) ? S_BS_RDB : S_BS_RDA;
      S_BS_RDB:  state_next = S_BS_RDD;
      S_BS_RDD:  state_next = S_BS_DIV;
      S_BS_DIV:  state_next = S_BS_WAIT;
      S_BS_WAIT: if (status.div_done) state_next = S_BS_WR;
      S_BS_WR:   state_next = (i == '0) ? S_OUT_RD : S_BS_INIT;
      S_OUT_RD:  state_next = S_OUT_WR;
      S_OUT_WR: begin
        if (status.out_free) state_next = (i == n_m1) ? S_LOAD : S_OUT_RD;
      end
      S_SING:    if (status.out_free) state_next = S_LOAD;
      default:   state_next = S_LOAD;
    endcase
  end

  // command outputs
  always_comb begin
    cmd.op   = OP_NONE;
    cmd.last = 1'b0;
    row      = i;
    col      = k;
    in_ready = 1'b0;
    case (state)
      S_LOAD: begin
        cmd.op   = OP_LOAD;
        in_ready = 1'b1;
      end
      S_PV_RD:   begin cmd.op = OP_READ;    row = j; col = i; end
      S_PV_CMP:  begin cmd.op = OP_PV_CMP;  row = j; col = i; end
      S_PV_CHK:  cmd.op = OP_NONE;
      S_SW_RDA:  cmd.op = OP_READ;
      S_SW_RDB:  cmd.op = OP_SW_RDB;
      S_SW_WRA:  cmd.op = OP_SW_WRA;
      S_SW_WRB:  cmd.op = OP_SW_WRB;
      S_EL_RDP:  begin cmd.op = OP_READ;    col = i; end
      S_EL_PIV:  cmd.op = OP_PIV;
      S_EL_RDJ:  begin cmd.op = OP_READ;    row = j; col = i; end
      S_EL_DIV:  cmd.op = OP_LAM_DIV;
      S_UP_RDI:  cmd.op = OP_READ;
      S_UP_MUL:  begin cmd.op = OP_UP_MUL;  row = j; end
      S_UP_WR:   begin cmd.op = OP_UP_WR;   row = j; end
      S_BS_INIT: cmd.op = OP_ACC_CLR;
      S_BS_RDA:  begin cmd.op = OP_READ;    col = j; end
      S_BS_RDX:  begin cmd.op = OP_RD_TMP;  row = j; col = n; end
      S_BS_MUL:  cmd.op = OP_BS_MUL;
      S_BS_ACC:  cmd.op = OP_BS_ACC;
      S_BS_RDB:  begin cmd.op = OP_READ;    col = n; end
      S_BS_RDD:  begin cmd.op = OP_RD_NUM;  col = i; end
      S_BS_DIV:  cmd.op = OP_X_DIV;
      S_BS_WR:   begin cmd.op = OP_X_WR;    col = n; end
      S_OUT_RD:  begin cmd.op = OP_READ;    col = n; end
      S_OUT_WR: begin
        if (status.out_free) begin
          cmd.op   = OP_OUT;
          cmd.last = (i == n_m1);
        end
      end
      S_SING:    if (status.out_free) cmd.op = OP_SING;
      default:   cmd.op = OP_NONE;
    endcase
  end

  // state and loop counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      i     <= '0;
      j     <= '0;
      k     <= '0;
    end else begin
      state <= state_next;
      if (cfg_we && cfg_index == REG_SIZE_IN_USE) begin
        // a size write clears the load counters i and k; the state is not changed
        i <= '0;
        k <= '0;
      end else begin
        case (state)
          S_LOAD: begin
            if (in_fire) begin
              if (k == n) begin
                k <= '0;
                if (i == n_m1) begin
                  i <= '0;
                  j <= '0;
                end else begin
                  i <= i + RCW'(1);
                end
              end else begin
                k <= k + RCW'(1);
              end
            end
          end
          S_PV_CMP:  if (j != n_m1) j <= j + RCW'(1);
          S_PV_CHK:  k <= i;
          S_SW_WRB:  if (k != n) k <= k + RCW'(1);
          S_EL_RDP:  j <= i + RCW'(1);
          S_EL_WAIT: k <= i + RCW'(1);
          S_UP_WR: begin
            if (k != n) begin
              k <= k + RCW'(1);
            end else if (j != n_m1) begin
              j <= j + RCW'(1);
            end else begin
              i <= i + RCW'(1);
              j <= i + RCW'(1);
            end
          end
          S_BS_INIT: j <= i + RCW'(1);
          S_BS_ACC:  if (j != n_m1) j <= j + RCW'(1);
          S_BS_WR:   if (i != '0) i <= i - RCW'(1);
          S_OUT_WR: begin
            if (status.out_free) begin
              if (i == n_m1) begin
                i <= '0;
                k <= '0;
              end else begin
                i <= i + RCW'(1);
              end
            end
          end
          S_SING: begin
            if (status.out_free) begin
              i <= '0;
              k <= '0;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/gaussian_elimination_solver_top.sv
// ---------------------------------------------------------------------------
// gaussian_elimination_solver_top
// Solves Ax=b for an n-by-(n+1) augmented matrix by elimination with
// partial pivoting and back substitution, signed Q16.16.
//
//   channel       dir  payload                                      notes
//   element_in    in   element_value                                row-major, rhs last
//   solution_out  out  solution_value, solution_index,              x[0..n-1] or one
//                      singular_flag, last_result                   singular result
//   cfg_*         in   cfg_we, cfg_index, cfg_data                  0 size, 1 threshold
//
// Loading accepts one element per cycle while element_in is valid. A solve is
// bounded by the single-port matrix store, which needs three accesses per update,
// and by the shared divider, which serves each multiplier and solution term in
// turn. Each result passes through a store read, then the result register; the
// solver holds in place while solution_out is stalled. Synchronous active-high
// reset clears control state; the matrix store is not cleared.
// ---------------------------------------------------------------------------
`default_nettype none

module gaussian_elimination_solver_top import gse_pkg::*; #(
  parameter int MAX_UNKNOWNS = MAX_UNKNOWNS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  gse_stream_if.sink           element_in,
  gse_stream_if.source         solution_out,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [THR_W-1:0]     cfg_data
);

  localparam int RCW = $clog2(MAX_UNKNOWNS + 1);

  dp_cmd_t    cmd;
  dp_status_t status;
  logic [RCW-1:0]   row;
  logic [RCW-1:0]   col;
  logic [RCW-1:0]   n;
  logic [THR_W-1:0] thr;
  logic             in_ready;
  logic             in_fire;
  logic             out_valid;
  out_item_t        out_item;
  in_item_t         in_item;

  // channel glue
  assign element_in.ready     = in_ready;
  assign in_fire              = element_in.valid && in_ready;
  assign in_item              = element_in.payload;
  assign solution_out.valid   = out_valid;
  assign solution_out.payload = out_item;

  gse_ctrl #(.MAX_UNKNOWNS(MAX_UNKNOWNS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_fire   (in_fire),
    .status    (status),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .row       (row),
    .col       (col),
    .n         (n),
    .thr       (thr)
  );

  gse_datapath #(.MAX_UNKNOWNS(MAX_UNKNOWNS)) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .row       (row),
    .col       (col),
    .n         (n),
    .thr       (thr),
    .in_fire   (in_fire),
    .in_item   (in_item),
    .out_ready (solution_out.ready),
    .status    (status),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire
